// ===== hdl/lpe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpe_pkg : shared types, constants and tables for the Laguerre evaluator
// Widths of the datapath, the microcode word and its ROM, and the constant
// function that yields the Horner coefficients at elaboration.
// ----------------------------------------------------------------------------
package lpe_pkg;

	// Port widths
	localparam int X_W   = 32;
	localparam int DEG_W = 4;
	localparam int ACC_W = 48;

	// Parameter defaults
	localparam int MAX_BASES_DEF = 10;
	localparam int FRAC_BITS_DEF = 16;

	// One lane per derivative order (value, first, second, third)
	localparam int N_LANES = 4;

	// Multiplier split: magnitude halves of 24 bits against a 32-bit |x|
	localparam int HALF_W = 24;
	localparam int PROD_W = HALF_W + X_W;   // one partial product
	localparam int FULL_W = 80;             // full product plus rounding
	localparam int MAG_W  = 49;             // clamped product magnitude, up to 2^48
	localparam int SUM_W  = 50;             // signed product plus coefficient

	// Microcode
	localparam int PC_W = 3;

	localparam logic [PC_W-1:0] ST_IDLE = 3'd0;
	localparam logic [PC_W-1:0] ST_MUL  = 3'd1;
	localparam logic [PC_W-1:0] ST_SUM  = 3'd2;
	localparam logic [PC_W-1:0] ST_UPD  = 3'd3;
	localparam logic [PC_W-1:0] ST_DONE = 3'd4;

	localparam logic [1:0] C_NONE     = 2'd0;
	localparam logic [1:0] C_NO_IN    = 2'd1;
	localparam logic [1:0] C_J_NZ     = 2'd2;
	localparam logic [1:0] C_OUT_BUSY = 2'd3;

	typedef struct packed {
		logic            ld;
		logic            mul;
		logic            sum;
		logic            upd;
		logic            push;
		logic [1:0]      cond;
		logic [PC_W-1:0] br_pc;
		logic [PC_W-1:0] nxt_pc;
	} ucode_t;

	// Qualified strobes from the sequencer to the datapath
	typedef struct packed {
		logic idle;
		logic take;
		logic mul;
		logic sum;
		logic upd;
		logic push;
	} ctrl_t;

	// Program: wait for a beat, then per coefficient multiply / round / accumulate,
	// loop while j is non-zero, then hand the result to the output register.
	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t w;
		w = '0;
		case (pc)
			ST_IDLE: begin
				w.ld = 1'b1; w.cond = C_NO_IN; w.br_pc = ST_IDLE; w.nxt_pc = ST_MUL;
			end
			ST_MUL: begin
				w.mul = 1'b1; w.cond = C_NONE; w.br_pc = ST_MUL; w.nxt_pc = ST_SUM;
			end
			ST_SUM: begin
				w.sum = 1'b1; w.cond = C_NONE; w.br_pc = ST_SUM; w.nxt_pc = ST_UPD;
			end
			ST_UPD: begin
				w.upd = 1'b1; w.cond = C_J_NZ; w.br_pc = ST_MUL; w.nxt_pc = ST_DONE;
			end
			ST_DONE: begin
				w.push = 1'b1; w.cond = C_OUT_BUSY; w.br_pc = ST_DONE; w.nxt_pc = ST_IDLE;
			end
			default: begin
				w.cond = C_NONE; w.br_pc = ST_IDLE; w.nxt_pc = ST_IDLE;
			end
		endcase
		return w;
	endfunction

	// Coefficient of x^j in the m-th derivative of L_d:
	// (-1)^(j+m) C(d,j+m) / j!, FRAC fraction bits, magnitude rounded half away.
	// Evaluated with constant arguments only.
	function automatic logic signed [ACC_W-1:0] coef_val(input int d, input int m,
			input int j, input int frac);
		longint unsigned row [17];
		longint unsigned num;
		longint unsigned f;
		longint unsigned q;
		longint unsigned rem;
		longint signed   v;
		int              k;
		for (int n = 0; n < 17; n++) row[n] = 0;
		row[0] = 1;
		// Pascal rows up to d
		for (int n = 1; n <= d; n++)
			for (int t = 16; t >= 1; t--)
				row[t] = row[t] + row[t-1];
		k = j + m;
		num = (k > d) ? 64'd0 : (row[k] << frac);
		f = 1;
		for (int n = 2; n <= j; n++) f = f * longint'(n);
		num = num + (f >> 1);
		// restoring long division
		q = 0;
		rem = 0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= f) begin
				rem = rem - f;
				q[b] = 1'b1;
			end
		end
		v = (k % 2 == 1) ? -longint'(q) : longint'(q);
		return v[ACC_W-1:0];
	endfunction

endpackage

// ===== hdl/lpe_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpe_seq : microcode sequencer
// Step counter over a read-only program; one control word per step, with a
// conditional jump selected by the word. Emits qualified strobes.
// ----------------------------------------------------------------------------
module lpe_seq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          j_nz,
	input  logic          out_busy,
	output lpe_pkg::ctrl_t ctrl
);
	import lpe_pkg::*;

	logic [PC_W-1:0] pc_q;
	ucode_t          uw;
	logic            br_take;

	// control word of the current step
	assign uw = ucode_rom(pc_q);

	// jump condition
	always_comb begin
		case (uw.cond)
			C_NONE:     br_take = 1'b0;
			C_NO_IN:    br_take = !in_valid;
			C_J_NZ:     br_take = j_nz;
			C_OUT_BUSY: br_take = out_busy;
			default:    br_take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_IDLE;
		end else begin
			pc_q <= br_take ? uw.br_pc : uw.nxt_pc;
		end
	end

	// strobes; take and push only when the handshake lets them through
	always_comb begin
		ctrl.idle = uw.ld;
		ctrl.take = uw.ld & in_valid;
		ctrl.mul  = uw.mul;
		ctrl.sum  = uw.sum;
		ctrl.upd  = uw.upd;
		ctrl.push = uw.push & !out_busy;
	end

	// an accepted beat starts the multiply step straight away
	a_take_mul: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.take |=> ctrl.mul)
		else $error("lpe_seq: accepted beat not followed by multiply step");

	// last coefficient done: go to hand-off
	a_end_done: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.upd && !j_nz) |=> (pc_q == ST_DONE))
		else $error("lpe_seq: loop exit did not reach hand-off step");

	// results leave only from the hand-off step
	a_push_done: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.push |-> (pc_q == ST_DONE))
		else $error("lpe_seq: result pushed outside hand-off step");

endmodule

// ===== hdl/lpe_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpe_lane : one Horner accumulator
// acc = sat(round(acc * x / 2^FRAC_BITS) + coef), sign-magnitude product split
// into two 24x32 partial products, round and clamp, then add and saturate.
// ----------------------------------------------------------------------------
module lpe_lane #(
	parameter int FRAC_BITS = lpe_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lpe_pkg::ctrl_t                    ctrl,
	input  logic                              en,
	input  logic [lpe_pkg::X_W-1:0]           xmag,
	input  logic                              xneg,
	input  logic signed [lpe_pkg::ACC_W-1:0]  coef,
	output logic signed [lpe_pkg::ACC_W-1:0]  acc,
	output logic                              ov
);
	import lpe_pkg::*;

	localparam logic [FULL_W-1:0] RND       = FULL_W'(1) << (FRAC_BITS - 1);
	localparam logic [FULL_W-1:0] PROD_CLMP = FULL_W'(1) << 48;

	logic signed [ACC_W-1:0]  acc_q;
	logic                     ov_q;
	logic [PROD_W-1:0]        pl_q;
	logic [PROD_W-1:0]        ph_q;
	logic                     sgn_q;
	logic [MAG_W-1:0]         mag_q;

	logic                     aneg;
	logic [ACC_W-1:0]         amag;
	logic [FULL_W-1:0]        full;
	logic [FULL_W-1:0]        shifted;
	logic signed [SUM_W-1:0]  pv;
	logic signed [SUM_W-1:0]  sum;
	logic signed [ACC_W-1:0]  sat_val;
	logic                     sat_hit;

	// magnitude of the accumulator
	assign aneg = acc_q[ACC_W-1];
	assign amag = aneg ? (~acc_q + 1'b1) : acc_q;

	// product assembly, rounding and clamp
	assign full    = {ph_q, HALF_W'(0)} + FULL_W'(pl_q) + RND;
	assign shifted = full >> FRAC_BITS;

	// signed product plus coefficient, saturated to 48 bits
	always_comb begin
		pv      = sgn_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
		sum     = pv + {{(SUM_W - ACC_W){coef[ACC_W-1]}}, coef};
		sat_hit = !((sum[SUM_W-1:ACC_W-1] == '0) || (sum[SUM_W-1:ACC_W-1] == '1));
		if (!sat_hit) begin
			sat_val = sum[ACC_W-1:0];
		end else if (sum[SUM_W-1]) begin
			sat_val = {1'b1, {(ACC_W-1){1'b0}}};
		end else begin
			sat_val = {1'b0, {(ACC_W-1){1'b1}}};
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (ctrl.mul) begin
			pl_q  <= PROD_W'(amag[HALF_W-1:0]) * PROD_W'(xmag);
			ph_q  <= PROD_W'(amag[ACC_W-1:HALF_W]) * PROD_W'(xmag);
			sgn_q <= aneg ^ xneg;
		end
		if (ctrl.sum) begin
			mag_q <= (shifted > PROD_CLMP) ? PROD_CLMP[MAG_W-1:0] : shifted[MAG_W-1:0];
		end
		if (ctrl.take) begin
			acc_q <= '0;
		end else if (ctrl.upd && en) begin
			acc_q <= sat_val;
		end
	end

	// sticky overflow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (ctrl.take) begin
			ov_q <= 1'b0;
		end else if (ctrl.upd && en && sat_hit) begin
			ov_q <= 1'b1;
		end
	end

	assign acc = acc_q;
	assign ov  = ov_q;

endmodule

// ===== hdl/laguerre_poly_eval_derivs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laguerre_poly_eval_derivs : Laguerre polynomial with three derivatives
// L_i(x), L_i', L_i'', L_i''' at a Q16.16 point, Q32.16 saturated results.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------
//  in      | in  | in_valid / in_stall  | x_value[31:0] s, degree[3:0]
//  out     | out | out_valid / out_stall| poly_value, first_deriv,
//          |     |                      | second_deriv, third_deriv [47:0] s,
//          |     |                      | overflow
//
//  With d the degree clamped to MAX_BASES-1, a beat runs the Horner loop over
//  d+1 coefficients, one coefficient per three-step pass (multiply, round,
//  accumulate), all four derivative lanes in parallel; the next beat is taken
//  only after the result has been handed to the output register.
//  Reset clears the sequencer and handshake state; no clearing pass.
//  A stalled result waits in the output register; the loop holds at hand-off.
// ----------------------------------------------------------------------------
module laguerre_poly_eval_derivs #(
	parameter int MAX_BASES = lpe_pkg::MAX_BASES_DEF,
	parameter int FRAC_BITS = lpe_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [lpe_pkg::X_W-1:0]    x_value,
	input  logic [lpe_pkg::DEG_W-1:0]         degree,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [lpe_pkg::ACC_W-1:0]  poly_value,
	output logic signed [lpe_pkg::ACC_W-1:0]  first_deriv,
	output logic signed [lpe_pkg::ACC_W-1:0]  second_deriv,
	output logic signed [lpe_pkg::ACC_W-1:0]  third_deriv,
	output logic                              overflow
);
	import lpe_pkg::*;

	localparam int IDX_W = (MAX_BASES > 1) ? $clog2(MAX_BASES) : 1;
	localparam int EN_W  = IDX_W + 2;

	ctrl_t                    ctrl;
	logic                     out_busy;
	logic [IDX_W-1:0]         d_in;
	logic [IDX_W-1:0]         d_q;
	logic [IDX_W-1:0]         j_q;
	logic [X_W-1:0]           xmag_q;
	logic                     xneg_q;
	logic                     out_valid_q;
	logic signed [ACC_W-1:0]  poly_q;
	logic signed [ACC_W-1:0]  d1_q;
	logic signed [ACC_W-1:0]  d2_q;
	logic signed [ACC_W-1:0]  d3_q;
	logic                     ovf_q;

	logic signed [ACC_W-1:0]  coef_tab [MAX_BASES][MAX_BASES][N_LANES];
	logic signed [ACC_W-1:0]  coef_q   [N_LANES];
	logic signed [ACC_W-1:0]  lane_acc [N_LANES];
	logic [N_LANES-1:0]       lane_ov;
	logic [N_LANES-1:0]       lane_en;

	assign out_busy = out_valid_q & out_stall;
	assign in_stall = !ctrl.idle;

	lpe_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.j_nz     (j_q != '0),
		.out_busy (out_busy),
		.ctrl     (ctrl)
	);

	// degree clamp
	assign d_in = ({1'b0, degree} >= 5'(MAX_BASES)) ? IDX_W'(MAX_BASES - 1)
		: IDX_W'(degree);

	// operand capture and coefficient counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_q <= '0;
			j_q <= '0;
		end else if (ctrl.take) begin
			d_q <= d_in;
			j_q <= d_in;
		end else if (ctrl.upd && (j_q != '0)) begin
			j_q <= j_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.take) begin
			xneg_q <= x_value[X_W-1];
			xmag_q <= x_value[X_W-1] ? (~x_value + 1'b1) : x_value;
		end
	end

	// constant coefficient table, one row of four per (degree, power)
	for (genvar gd = 0; gd < MAX_BASES; gd++) begin : g_tab_d
		for (genvar gj = 0; gj < MAX_BASES; gj++) begin : g_tab_j
			for (genvar gm = 0; gm < N_LANES; gm++) begin : g_tab_m
				assign coef_tab[gd][gj][gm] = coef_val(gd, gm, gj, FRAC_BITS);
			end
		end
	end

	// lanes: order m joins the loop once j + m <= d
	for (genvar gm = 0; gm < N_LANES; gm++) begin : g_lane
		always_ff @(posedge clk) begin
			if (ctrl.mul) begin
				coef_q[gm] <= coef_tab[d_q][j_q][gm];
			end
		end

		assign lane_en[gm] = (EN_W'(j_q) + EN_W'(gm)) <= EN_W'(d_q);

		lpe_lane #(
			.FRAC_BITS (FRAC_BITS)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.en     (lane_en[gm]),
			.xmag   (xmag_q),
			.xneg   (xneg_q),
			.coef   (coef_q[gm]),
			.acc    (lane_acc[gm]),
			.ov     (lane_ov[gm])
		);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.push) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			poly_q <= lane_acc[0];
			d1_q   <= lane_acc[1];
			d2_q   <= lane_acc[2];
			d3_q   <= lane_acc[3];
			ovf_q  <= |lane_ov;
		end
	end

	assign out_valid    = out_valid_q;
	assign poly_value   = poly_q;
	assign first_deriv  = d1_q;
	assign second_deriv = d2_q;
	assign third_deriv  = d3_q;
	assign overflow     = ovf_q;

	// coefficient counter never runs past the degree
	a_j_range: assert property (@(posedge clk) disable iff (!arst_n)
		j_q <= d_q)
		else $error("lpe: coefficient index above degree");

	// third derivative of a polynomial below degree three is zero
	a_d3_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.push && (EN_W'(d_q) < EN_W'(3))) |-> (lane_acc[3] == '0))
		else $error("lpe: third-derivative lane not zero for low degree");

	// a hand-off always shows up as a valid result beat
	a_push_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.push |=> out_valid)
		else $error("lpe: result hand-off without valid beat");

endmodule

// ===== test/laguerre_poly_eval_derivs_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laguerre_poly_eval_derivs_tb : self-checking bench for the Laguerre evaluator
// A short table of directed points (zero, unit, full-scale and clamped
// degrees) and then random points and degrees are pushed through the block.
// Every result beat is checked field by field against a typed-in beat or a
// fixed-point Horner predictor held in the bench. Both channels idle at random, the result side
// holds off for long stretches and the bench drains the block mid-run.
// ----------------------------------------------------------------------------
module laguerre_poly_eval_derivs_tb;

	localparam int     FRAC     = lpe_pkg::FRAC_BITS_DEF;
	localparam int     TOP_DEG  = lpe_pkg::MAX_BASES_DEF - 1;
	localparam longint SAT_HI   = (64'sd1 <<< 47) - 1;
	localparam longint SAT_LO   = -(64'sd1 <<< 47);
	localparam longint ONE      = 64'sd1 <<< FRAC;
	localparam int     N_RANDOM = 1330;
	localparam int     HOLD_LEN = 300;
	localparam int     TAIL     = 40;

	// One result beat
	typedef struct packed {
		logic signed [lpe_pkg::ACC_W-1:0] val;
		logic signed [lpe_pkg::ACC_W-1:0] d1;
		logic signed [lpe_pkg::ACC_W-1:0] d2;
		logic signed [lpe_pkg::ACC_W-1:0] d3;
		logic                             ovf;
	} lag_res_t;

	// Directed row: expected beat typed in, or left to the predictor
	typedef struct {
		logic signed [lpe_pkg::X_W-1:0] x;
		logic [lpe_pkg::DEG_W-1:0]      deg;
		bit                             typed;
		lag_res_t                       res;
	} stim_row_t;

	logic                             clk;
	logic                             arst_n    = 1'b0;
	logic                             in_valid  = 1'b0;
	logic                             in_stall;
	logic signed [lpe_pkg::X_W-1:0]   x_value   = '0;
	logic [lpe_pkg::DEG_W-1:0]        degree    = '0;
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	logic signed [lpe_pkg::ACC_W-1:0] poly_value;
	logic signed [lpe_pkg::ACC_W-1:0] first_deriv;
	logic signed [lpe_pkg::ACC_W-1:0] second_deriv;
	logic signed [lpe_pkg::ACC_W-1:0] third_deriv;
	logic                             overflow;

	lag_res_t  due_evals [$];
	stim_row_t dir_rows [$];

	int n_mismatch  = 0;
	int n_sent      = 0;
	int n_checked   = 0;
	int n_saturated = 0;
	int n_clamped   = 0;
	int n_blocked   = 0;

	// result-side idling control
	int hold_asked  = 0;
	int hold_served = 0;
	int hold_left   = 0;
	int run_left    = 0;
	bit run_stall   = 1'b0;
	bit quiet_rx    = 1'b0;

	laguerre_poly_eval_derivs dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.x_value      (x_value),
		.degree       (degree),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.poly_value   (poly_value),
		.first_deriv  (first_deriv),
		.second_deriv (second_deriv),
		.third_deriv  (third_deriv),
		.overflow     (overflow)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// (-1)^(j+m) C(d,j+m) / j!, magnitude rounded half away from zero
	function automatic longint lag_coef(input int d, input int m, input int j);
		longint unsigned binom;
		longint unsigned fct;
		longint unsigned q;
		int              k;
		k = j + m;
		if (k > d)
			return 0;
		binom = 1;
		for (int t = 0; t < k; t++)
			binom = binom * longint'(d - t) / longint'(t + 1);
		fct = 1;
		for (int n = 2; n <= j; n++)
			fct = fct * longint'(n);
		q = ((binom << FRAC) + fct / 2) / fct;
		return (k % 2 == 1) ? -longint'(q) : longint'(q);
	endfunction

	// acc*x rounded, product clamped to 2^48, plus coefficient, saturated
	function automatic longint horner_mac(input longint acc, input logic [32:0] xmag,
			input bit xneg, input longint c, inout bit sat_hit);
		logic [127:0] prod;
		logic [63:0]  amag;
		longint       p;
		longint       s;
		bit           aneg;
		aneg = (acc < 0);
		amag = aneg ? -acc : acc;
		prod = {64'd0, amag} * {95'd0, xmag};
		prod = (prod + (128'd1 << (FRAC - 1))) >> FRAC;
		if (prod > (128'd1 << 48))
			prod = 128'd1 << 48;
		p = (aneg != xneg) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
		s = p + c;
		if (s > SAT_HI) begin
			s = SAT_HI;
			sat_hit = 1'b1;
		end else if (s < SAT_LO) begin
			s = SAT_LO;
			sat_hit = 1'b1;
		end
		return s;
	endfunction

	// All four lanes: value and derivatives one to three
	function automatic lag_res_t laguerre_eval(input logic signed [31:0] xv,
			input logic [3:0] dg);
		lag_res_t    r;
		logic [32:0] xmag;
		bit          xneg;
		bit          sat_hit;
		int          d;
		longint      acc;
		longint      lanes [4];
		xneg    = xv[31];
		xmag    = xneg ? (33'h1_0000_0000 - {1'b0, xv}) : {1'b0, xv};
		d       = (dg > TOP_DEG) ? TOP_DEG : int'(dg);
		sat_hit = 1'b0;
		for (int m = 0; m < 4; m++) begin
			acc = 0;
			if (m <= d) begin
				acc = lag_coef(d, m, d - m);
				for (int j = d - m - 1; j >= 0; j--)
					acc = horner_mac(acc, xmag, xneg, lag_coef(d, m, j), sat_hit);
			end
			lanes[m] = acc;
		end
		r.val = lanes[0][47:0];
		r.d1  = lanes[1][47:0];
		r.d2  = lanes[2][47:0];
		r.d3  = lanes[3][47:0];
		r.ovf = sat_hit;
		return r;
	endfunction

	function automatic lag_res_t mk_res(input longint v, input longint a,
			input longint b, input longint c);
		lag_res_t r;
		r.val = v[47:0];
		r.d1  = a[47:0];
		r.d2  = b[47:0];
		r.d3  = c[47:0];
		r.ovf = 1'b0;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	task automatic add_row(input logic signed [31:0] xv, input logic [3:0] dg,
			input bit typed, input lag_res_t res);
		stim_row_t row;
		row.x     = xv;
		row.deg   = dg;
		row.typed = typed;
		row.res   = res;
		dir_rows.push_back(row);
	endtask

	function automatic logic signed [31:0] rand_point();
		int sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0, 1, 2, 3: return int'($urandom_range(0, 1 << 20)) - (1 << 19);
			4, 5:       return int'($urandom_range(0, 1 << 25)) - (1 << 24);
			6, 7:       return $urandom;
			8: begin
				case ($urandom_range(0, 6))
					0:       return 32'sh7FFF_FFFF;
					1:       return 32'sh8000_0000;
					2:       return 32'sh0000_0000;
					3:       return -32'sd1;
					4:       return 32'sd1;
					5:       return 32'sh0001_0000;
					default: return -32'sh0001_0000;
				endcase
			end
			default:    return (int'($urandom_range(0, 40)) - 20) <<< FRAC;
		endcase
	endfunction

	function automatic logic [3:0] rand_degree();
		if ($urandom_range(0, 99) < 85)
			return 4'($urandom_range(0, TOP_DEG));
		return 4'($urandom_range(TOP_DEG + 1, 15));
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int rand_gap();
		int sel;
		sel = $urandom_range(0, 19);
		if (sel < 10)
			return 0;
		if (sel < 17)
			return $urandom_range(1, 3);
		if (sel < 19)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Offer one beat, hold it until taken, then queue its expected result
	task automatic send_beat(input logic signed [31:0] xv, input logic [3:0] dg,
			input bit typed, input lag_res_t typed_res, input int gap);
		in_valid <= 1'b1;
		x_value  <= xv;
		degree   <= dg;
		@(posedge clk);
		while (!(in_valid && !in_stall)) begin
			n_blocked++;
			@(posedge clk);
		end
		due_evals.push_back(typed ? typed_res : laguerre_eval(xv, dg));
		n_sent++;
		if (dg > TOP_DEG)
			n_clamped++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	task automatic flag_mismatch(input string msg);
		n_mismatch++;
		$display("%0t ns mismatch: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic signed [47:0] got,
			input logic signed [47:0] want);
		if (got !== want)
			flag_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
	endtask

	// Result side: check each taken beat, then pick the next stall level
	always @(posedge clk) begin
		lag_res_t want;
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			if (due_evals.size() == 0) begin
				flag_mismatch("result beat with nothing pending");
			end else begin
				want = due_evals.pop_front();
				check_field("poly_value", poly_value, want.val);
				check_field("first_deriv", first_deriv, want.d1);
				check_field("second_deriv", second_deriv, want.d2);
				check_field("third_deriv", third_deriv, want.d3);
				if (overflow !== want.ovf)
					flag_mismatch($sformatf("overflow got %b, want %b", overflow, want.ovf));
				n_checked++;
				if (want.ovf)
					n_saturated++;
			end
		end
		// long hold-off, counted here
		if (hold_served != hold_asked) begin
			hold_served = hold_asked;
			hold_left   = HOLD_LEN;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (quiet_rx) begin
			out_stall <= 1'b0;
		end else begin
			if (run_left == 0) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: begin
						run_stall = 1'b0;
						run_left  = $urandom_range(1, 30);
					end
					6, 7, 8: begin
						run_stall = 1'b1;
						run_left  = $urandom_range(1, 3);
					end
					default: begin
						run_stall = 1'b1;
						run_left  = $urandom_range(10, 40);
					end
				endcase
			end
			run_left--;
			out_stall <= run_stall;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------

	initial begin
		// directed points; x = 0 gives the constant terms of each lane
		add_row(32'sd0, 4'd0, 1'b1, mk_res(ONE, 0, 0, 0));
		add_row(32'sd0, 4'd3, 1'b1, mk_res(ONE, -3 * ONE, 3 * ONE, -ONE));
		add_row(32'sd0, 4'd9, 1'b1, mk_res(ONE, -9 * ONE, 36 * ONE, -84 * ONE));
		add_row(32'sd0, 4'd15, 1'b1, mk_res(ONE, -9 * ONE, 36 * ONE, -84 * ONE));
		add_row(32'sh7FFF_FFFF, 4'd0, 1'b1, mk_res(ONE, 0, 0, 0));
		add_row(32'sh8000_0000, 4'd0, 1'b1, mk_res(ONE, 0, 0, 0));
		// L_1(x) = 1 - x
		add_row(32'sh7FFF_FFFF, 4'd1, 1'b1, mk_res(ONE - 64'sh7FFF_FFFF, -ONE, 0, 0));
		add_row(32'sh8000_0000, 4'd1, 1'b1, mk_res(ONE + 64'sh8000_0000, -ONE, 0, 0));
		add_row(32'sh0001_0000, 4'd1, 1'b1, mk_res(0, -ONE, 0, 0));
		// full scale and tiny magnitudes, saturation at high degree
		add_row(32'sh7FFF_FFFF, 4'd9, 1'b0, '0);
		add_row(32'sh8000_0000, 4'd9, 1'b0, '0);
		add_row(32'sh7FFF_0000, 4'd4, 1'b0, '0);
		add_row(32'sh8000_0000, 4'd3, 1'b0, '0);
		add_row(-32'sd1, 4'd9, 1'b0, '0);
		add_row(32'sd1, 4'd9, 1'b0, '0);
		add_row(32'sh0001_0000, 4'd5, 1'b0, '0);
		add_row(32'sh0002_0000, 4'd2, 1'b0, '0);
		add_row(-32'sh0003_8000, 4'd7, 1'b0, '0);
		add_row(32'sh0028_0000, 4'd9, 1'b0, '0);
		add_row(32'sh0000_8000, 4'd8, 1'b0, '0);
		// degrees above the top one are clamped
		add_row(32'sh0004_4000, 4'd10, 1'b0, '0);
		add_row(-32'sh0001_2000, 4'd12, 1'b0, '0);
		add_row(32'sh1234_5678, 4'd15, 1'b0, '0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_beat(dir_rows[i].x, dir_rows[i].deg, dir_rows[i].typed,
				dir_rows[i].res, rand_gap());

		for (int n = 0; n < N_RANDOM; n++) begin
			int gap;
			gap = rand_gap();
			// receiver holds off while beats keep coming
			if (n == 300 || n == 1100)
				hold_asked++;
			if ((n >= 300 && n < 340) || (n >= 1100 && n < 1130))
				gap = 0;
			// sender waits for the block to drain
			if (n == 600 || n == 1000) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (due_evals.size() != 0)
					@(posedge clk);
			end
			// stretch with no idling on either side
			quiet_rx = (n >= 800 && n < 950);
			if (quiet_rx)
				gap = 0;
			send_beat(rand_point(), rand_degree(), 1'b0, '0, gap);
		end
		in_valid <= 1'b0;
		quiet_rx = 1'b0;

		while (due_evals.size() != 0)
			@(posedge clk);
		repeat (TAIL) @(posedge clk);

		$display("%0d points sent (%0d with clamped degree), %0d results checked,",
			n_sent, n_clamped, n_checked);
		$display("%0d saturated, %0d stalled offers, %0d mismatches",
			n_saturated, n_blocked, n_mismatch);
		if (n_mismatch == 0)
			$display("[laguerre_poly_eval_derivs] OK");
		else
			$display("[laguerre_poly_eval_derivs] ERROR");
		$finish;
	end

	// watchdog
	initial begin
		#1500000;
		$display("[laguerre_poly_eval_derivs] ERROR");
		$finish;
	end

endmodule
